>>> design/sao_pkg.sv
// ----------------------------------------------------------------------------
// sao_pkg
// Shared types and codes of the stack allocator: operation and status codes,
// register indexes and the packed layouts of the stream beats.
// ----------------------------------------------------------------------------
`default_nettype none

package sao_pkg;

  // Offset, size and top fields
  localparam int OFS_W = 13;
  // Alignment exponent fields
  localparam int LOG_W = 4;
  // Working width of the placement arithmetic: covers top plus header plus
  // the widest alignment mask plus a size, and the largest pool size
  localparam int CALC_W = 18;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int S_DATA_W   = 32;
  localparam int S_USER_W   = 2;
  localparam int M_DATA_W   = 48;

  typedef enum logic [S_USER_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_RESET = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_SIZE = 2'd1,
    STATUS_BAD_ALIGN = 2'd2,
    STATUS_NO_ROOM   = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_ALIGN_LOG2 = 1'b1;

  // Input beat payload, lowest bits last in the declaration
  typedef struct packed {
    logic [1:0]       pad;
    logic [OFS_W-1:0] free_offset;
    logic [LOG_W-1:0] req_align_log2;
    logic [OFS_W-1:0] req_size;
  } in_item_t;

  // Result beat payload, lowest bits last in the declaration
  typedef struct packed {
    logic [6:0]       pad;
    logic [OFS_W-1:0] peak_bytes;
    logic [OFS_W-1:0] used_bytes;
    logic [OFS_W-1:0] user_offset;
    status_t          status;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/sao_ram.sv
// ----------------------------------------------------------------------------
// sao_ram
// Generic single-write, single-read RAM with a registered read port. The read
// data holds until the next read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module sao_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/stack_allocator_offsets.sv
// ----------------------------------------------------------------------------
// stack_allocator_offsets
// LIFO stack allocator over a byte pool, worked in offsets from pool start.
// ----------------------------------------------------------------------------
// In the accept cycle the item is registered and the previous-top store (a
// POOL_MAX_BYTES x 13 synchronous RAM) is read at free_offset; then, once the
// result register is free, the alloc/free/reset is worked out against the top
// offset and loaded into the result register, where an alloc also
// writes the old top into the store. A new item is taken once the previous
// one has reached the result register, even while that result waits on
// m_tready; a full result register holds the second item in its work cycle.
// The store is not cleared after reset: freeing an offset that no alloc
// returned gives an undefined top. Reset of the stack (func 2) clears the
// top only; the peak is cleared by rst alone.
`default_nettype none

module stack_allocator_offsets #(
  parameter int POOL_MAX_BYTES = 4096,
  parameter int HEADER_BYTES   = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Configuration write port
  input  wire logic                           cfg_wen,
  input  wire logic [sao_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sao_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Request stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // s_tuser: func[1:0]
  input  wire logic [sao_pkg::S_USER_W-1:0]   s_tuser,
  // s_tdata: req_size[12:0], req_align_log2[16:13], free_offset[29:17], zero pad
  input  wire logic [sao_pkg::S_DATA_W-1:0]   s_tdata,
  // Result stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // m_tdata: status[1:0], user_offset[14:2], used_bytes[27:15],
  //          peak_bytes[40:28], zero pad
  output logic      [sao_pkg::M_DATA_W-1:0]   m_tdata
);

  localparam int AW = $clog2(POOL_MAX_BYTES);
  localparam int OW = sao_pkg::OFS_W;
  localparam int CW = sao_pkg::CALC_W;

  // Configuration registers
  logic [OW-1:0]               pool_bytes;
  logic [sao_pkg::LOG_W-1:0]   pool_align_log2;

  // Control and held item
  logic                        busy;
  sao_pkg::func_t              func;
  sao_pkg::in_item_t           item;
  sao_pkg::in_item_t           s_item;

  // Allocator state
  logic [OW-1:0]               top_offset;
  logic [OW-1:0]               peak_offset;
  logic [OW-1:0]               top_offset_next;
  logic [OW-1:0]               peak_offset_next;

  sao_pkg::out_item_t          result;
  sao_pkg::out_item_t          result_next;

  // Placement arithmetic
  logic [CW-1:0]               eff_pool;
  logic [CW-1:0]               align_mask;
  logic [CW-1:0]               after_hdr;
  logic [CW-1:0]               cand;
  logic [CW-1:0]               new_top;
  logic                        do_op;
  logic                        store_wr;
  logic [OW-1:0]               store_rd_data;

  assign s_item   = sao_pkg::in_item_t'(s_tdata);
  assign s_tready = !busy;
  assign do_op    = busy && (!m_tvalid || m_tready);
  assign m_tdata  = result;

  // Clamp pool size to the store depth
  assign eff_pool = (CW'(pool_bytes) > CW'(POOL_MAX_BYTES)) ? CW'(POOL_MAX_BYTES)
                                                            : CW'(pool_bytes);

  // Header after the top, then round up to the requested alignment
  assign align_mask = (CW'(1) << item.req_align_log2) - CW'(1);
  assign after_hdr  = CW'(top_offset) + CW'(HEADER_BYTES);
  assign cand       = (after_hdr + align_mask) & ~align_mask;
  assign new_top    = cand + CW'(item.req_size);

  // Work out the operation on the held item
  always_comb begin
    top_offset_next    = top_offset;
    peak_offset_next   = peak_offset;
    store_wr           = 1'b0;
    result_next        = '0;
    result_next.status = sao_pkg::STATUS_OK;
    unique case (func)
      sao_pkg::FUNC_ALLOC: begin
        if (item.req_size == '0) begin
          result_next.status = sao_pkg::STATUS_ZERO_SIZE;
        end else if (item.req_align_log2 > pool_align_log2) begin
          result_next.status = sao_pkg::STATUS_BAD_ALIGN;
        end else if (new_top > eff_pool || cand >= CW'(POOL_MAX_BYTES)) begin
          result_next.status = sao_pkg::STATUS_NO_ROOM;
        end else begin
          store_wr                = 1'b1;
          top_offset_next         = new_top[OW-1:0];
          result_next.user_offset = cand[OW-1:0];
          if (new_top[OW-1:0] > peak_offset) begin
            peak_offset_next = new_top[OW-1:0];
          end
        end
      end
      sao_pkg::FUNC_FREE: begin
        if (item.free_offset != '0 && CW'(item.free_offset) < eff_pool &&
            CW'(item.free_offset) < CW'(POOL_MAX_BYTES)) begin
          top_offset_next = store_rd_data;
        end
      end
      sao_pkg::FUNC_RESET: begin
        top_offset_next = '0;
      end
      sao_pkg::FUNC_NOP: begin
      end
      default: begin
      end
    endcase
    result_next.used_bytes = top_offset_next;
    result_next.peak_bytes = peak_offset_next;
  end

  // Previous-top store, indexed by user offset
  sao_ram #(
    .WIDTH (OW),
    .DEPTH (POOL_MAX_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (do_op && store_wr),
    .wr_addr (AW'(cand)),
    .wr_data (top_offset),
    .rd_en   (s_tvalid && s_tready),
    .rd_addr (AW'(s_item.free_offset)),
    .rd_data (store_rd_data)
  );

  // Hold configuration, item, allocator state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_bytes      <= OW'(4096);
      pool_align_log2 <= sao_pkg::LOG_W'(4);
      busy            <= 1'b0;
      m_tvalid        <= 1'b0;
      top_offset      <= '0;
      peak_offset     <= '0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          sao_pkg::REG_POOL_BYTES:      pool_bytes      <= cfg_wdata[OW-1:0];
          sao_pkg::REG_POOL_ALIGN_LOG2: pool_align_log2 <= cfg_wdata[sao_pkg::LOG_W-1:0];
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready) begin
        busy <= 1'b1;
        func <= sao_pkg::func_t'(s_tuser);
        item <= s_item;
      end
      if (do_op) begin
        busy        <= 1'b0;
        m_tvalid    <= 1'b1;
        result      <= result_next;
        top_offset  <= top_offset_next;
        peak_offset <= peak_offset_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/sao_checker.sv
// ----------------------------------------------------------------------------
// sao_checker
// Port-level checks of the stack allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sao_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic [sao_pkg::M_DATA_W-1:0] m_tdata,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready
);

  sao_pkg::out_item_t res;
  assign res = sao_pkg::out_item_t'(m_tdata);

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat accepted while an item is in work");

  // A failed alloc hands out no offset
  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.status != sao_pkg::STATUS_OK |-> res.user_offset == '0)
    else $error("offset returned with a failure status");

  // A handed-out region lies below the new top
  a_region: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.user_offset != '0 |-> res.used_bytes > res.user_offset)
    else $error("top not above the returned offset");

endmodule

bind stack_allocator_offsets sao_checker u_sao_checker (.*);

`default_nettype wire
